// ===== hw/rtl/touch_tap_hold_classifier_core_defines.svh =====
// Assertion macros shared by the touch classifier RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef TOUCH_TAP_HOLD_CLASSIFIER_CORE_DEFINES_SVH
`define TOUCH_TAP_HOLD_CLASSIFIER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TTHC_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tthc assertion failed");
`define TTHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tthc assertion failed");
`else
`define TTHC_ASSERT_ALWAYS(label, expr)
`define TTHC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/tthc_pkg.sv =====
// Shared types and constants of the touch tap/hold classifier.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none
package tthc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int THR_BITS    = 12;
    localparam int MS_BITS     = 16;
    localparam int TIME_BITS   = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam int MAX_RESULTS = 2;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_BITS-1:0] REG_TOUCH_THR   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE_THR = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE    = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD        = CFG_IDX_BITS'(3);

    localparam logic [THR_BITS-1:0] TOUCH_THR_RESET   = THR_BITS'(2000);
    localparam logic [THR_BITS-1:0] RELEASE_THR_RESET = THR_BITS'(1800);
    localparam logic [MS_BITS-1:0]  DEBOUNCE_RESET    = MS_BITS'(50);
    localparam logic [MS_BITS-1:0]  HOLD_RESET        = MS_BITS'(1000);

    typedef enum logic [1:0] {
        EV_START = 2'd0,
        EV_HOLD  = 2'd1,
        EV_TAP   = 2'd2,
        EV_END   = 2'd3
    } event_kind_t;

    typedef struct packed {
        event_kind_t            kind;
        logic [SAMPLE_BITS-1:0] pressure;
        logic [TIME_BITS-1:0]   duration;
        logic [TIME_BITS-1:0]   stamp;
        logic [TIME_BITS-1:0]   touches;
        logic [TIME_BITS-1:0]   holds;
        logic                   last;
    } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tthc_sample_if.sv =====
// Input channel of the touch classifier: one converter sample and its time.
// Depends on tthc_pkg for field widths.
`default_nettype none
interface tthc_sample_if;
    logic                             valid;
    logic                             ready;
    logic [tthc_pkg::SAMPLE_BITS-1:0] raw_sample;
    logic [tthc_pkg::TIME_BITS-1:0]   now_ms;

    modport source (output valid, output raw_sample, output now_ms, input ready);
    modport sink (input valid, input raw_sample, input now_ms, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tthc_event_if.sv =====
// Output channel of the touch classifier: one touch event per item.
// Depends on tthc_pkg for field widths.
`default_nettype none
interface tthc_event_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       event_kind;
    logic [tthc_pkg::SAMPLE_BITS-1:0] pressure;
    logic [tthc_pkg::TIME_BITS-1:0]   press_duration;
    logic [tthc_pkg::TIME_BITS-1:0]   event_time;
    logic [tthc_pkg::TIME_BITS-1:0]   touch_count;
    logic [tthc_pkg::TIME_BITS-1:0]   hold_count;
    logic                             last_of_run;

    modport source (output valid, output event_kind, output pressure, output press_duration,
                    output event_time, output touch_count, output hold_count,
                    output last_of_run, input ready);
    modport sink (input valid, input event_kind, input pressure, input press_duration,
                  input event_time, input touch_count, input hold_count,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/touch_tap_hold_classifier_core.sv =====
// Touch tap/hold classifier: filter, hysteresis, debounce and event queue.
// An accepted sample's events are registered into the event queue.
// Throughput: one sample per cycle while two entries are free; a release queues
// two events, so the four-entry event queue and one pop per cycle set the rate.
// Reset: asynchronous, active low; registers return to defaults, queue empties.
// Depends on tthc_pkg, tthc_sample_if, tthc_event_if and the defines header.
`default_nettype none
`include "touch_tap_hold_classifier_core_defines.svh"
module touch_tap_hold_classifier_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tthc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [tthc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    tthc_sample_if.sink                          samples,
    tthc_event_if.source                         events
);

    logic [tthc_pkg::THR_BITS-1:0]    touch_thr_reg;
    logic [tthc_pkg::THR_BITS-1:0]    release_thr_reg;
    logic [tthc_pkg::MS_BITS-1:0]     debounce_reg;
    logic [tthc_pkg::MS_BITS-1:0]     hold_reg;

    logic [tthc_pkg::SAMPLE_BITS-1:0] filter_reg,  filter_next;
    logic                             seeded_reg,  seeded_next;
    logic                             touched_reg, touched_next;
    logic [tthc_pkg::TIME_BITS-1:0]   start_reg,   start_next;
    logic [tthc_pkg::TIME_BITS-1:0]   touches_reg, touches_next;
    logic [tthc_pkg::TIME_BITS-1:0]   holds_reg,   holds_next;

    tthc_pkg::result_t                fifo_mem [tthc_pkg::FIFO_DEPTH];
    logic [tthc_pkg::PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tthc_pkg::PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tthc_pkg::CNT_BITS-1:0]    count_reg,  count_next;

    logic                             accept;
    logic                             pop;
    logic [1:0]                       push_num;
    tthc_pkg::result_t                res0;
    tthc_pkg::result_t                res1;
    tthc_pkg::result_t                head;

    assign samples.ready = (count_reg <=
        tthc_pkg::CNT_BITS'(tthc_pkg::FIFO_DEPTH - tthc_pkg::MAX_RESULTS));
    assign accept = samples.valid && samples.ready;
    assign pop    = events.valid && events.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_thr_reg   <= tthc_pkg::TOUCH_THR_RESET;
            release_thr_reg <= tthc_pkg::RELEASE_THR_RESET;
            debounce_reg    <= tthc_pkg::DEBOUNCE_RESET;
            hold_reg        <= tthc_pkg::HOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tthc_pkg::REG_TOUCH_THR:   touch_thr_reg   <= cfg_data[tthc_pkg::THR_BITS-1:0];
                tthc_pkg::REG_RELEASE_THR: release_thr_reg <= cfg_data[tthc_pkg::THR_BITS-1:0];
                tthc_pkg::REG_DEBOUNCE:    debounce_reg    <= cfg_data[tthc_pkg::MS_BITS-1:0];
                tthc_pkg::REG_HOLD:        hold_reg        <= cfg_data[tthc_pkg::MS_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        logic [tthc_pkg::SAMPLE_BITS+2:0] mix;
        logic [tthc_pkg::SAMPLE_BITS-1:0] filt;
        logic [tthc_pkg::TIME_BITS-1:0]   since;
        logic                             level;

        mix   = {filter_reg, 3'b000} - {3'b000, filter_reg} + {3'b000, samples.raw_sample};
        filt  = mix[tthc_pkg::SAMPLE_BITS+2:3];
        level = touched_reg ? (filt > release_thr_reg) : (filt > touch_thr_reg);
        since = samples.now_ms - start_reg;

        filter_next  = filter_reg;
        seeded_next  = seeded_reg;
        touched_next = touched_reg;
        start_next   = start_reg;
        touches_next = touches_reg;
        holds_next   = holds_reg;
        push_num     = 2'd0;

        if (accept)
        begin
            seeded_next = 1'b1;
            if (!seeded_reg)
            begin
                filter_next = samples.raw_sample;
            end
            else
            begin
                filter_next = filt;
                if ((level != touched_reg) &&
                    (since > {{(tthc_pkg::TIME_BITS-tthc_pkg::MS_BITS){1'b0}}, debounce_reg}))
                begin
                    touched_next = level;
                    if (level)
                    begin
                        start_next   = samples.now_ms;
                        touches_next = touches_reg + 1'b1;
                        push_num     = 2'd1;
                    end
                    else
                    begin
                        if (since >= {{(tthc_pkg::TIME_BITS-tthc_pkg::MS_BITS){1'b0}}, hold_reg})
                        begin
                            holds_next = holds_reg + 1'b1;
                        end
                        push_num = 2'd2;
                    end
                end
            end
        end

        res0.pressure = filt;
        res0.stamp    = samples.now_ms;
        res0.touches  = touches_next;
        res0.holds    = holds_next;
        if (push_num == 2'd1)
        begin
            res0.kind     = tthc_pkg::EV_START;
            res0.duration = '0;
            res0.last     = 1'b1;
        end
        else
        begin
            res0.kind     = (holds_next != holds_reg) ? tthc_pkg::EV_HOLD : tthc_pkg::EV_TAP;
            res0.duration = since;
            res0.last     = 1'b0;
        end
        res1          = res0;
        res1.kind     = tthc_pkg::EV_END;
        res1.duration = since;
        res1.last     = 1'b1;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + tthc_pkg::PTR_BITS'(push_num);
        rd_ptr_next = rd_ptr_reg + tthc_pkg::PTR_BITS'(pop);
        count_next  = count_reg + tthc_pkg::CNT_BITS'(push_num) - tthc_pkg::CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg  <= '0;
            seeded_reg  <= 1'b0;
            touched_reg <= 1'b0;
            start_reg   <= '0;
            touches_reg <= '0;
            holds_reg   <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            filter_reg  <= filter_next;
            seeded_reg  <= seeded_next;
            touched_reg <= touched_next;
            start_reg   <= start_next;
            touches_reg <= touches_next;
            holds_reg   <= holds_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (push_num == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    assign head                  = fifo_mem[rd_ptr_reg];
    assign events.valid          = (count_reg != '0);
    assign events.event_kind     = head.kind;
    assign events.pressure       = head.pressure;
    assign events.press_duration = head.duration;
    assign events.event_time     = head.stamp;
    assign events.touch_count    = head.touches;
    assign events.hold_count     = head.holds;
    assign events.last_of_run    = head.last;

    `TTHC_ASSERT_ALWAYS(a_count_bound,
        count_reg <= tthc_pkg::CNT_BITS'(tthc_pkg::FIFO_DEPTH))
    `TTHC_ASSERT_NEXT(a_release_pair,
        pop && !events.last_of_run,
        events.valid && (events.event_kind == tthc_pkg::EV_END))
    `TTHC_ASSERT_NEXT(a_start_sets_touch, push_num == 2'd1, touched_reg)
    `TTHC_ASSERT_NEXT(a_seed_once, accept && !seeded_reg, seeded_reg && (count_reg == $past(count_reg) - tthc_pkg::CNT_BITS'($past(pop))))

endmodule
`default_nettype wire
